// ===== src/dfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfp_pkg: decimal text parser shared types
// Parse phase encoding, parse state record, character codes and limits.
// ----------------------------------------------------------------------------
package dfp_pkg;

   localparam int unsigned MaxDigits = 19;
   localparam int unsigned KeptW     = 5;

   localparam logic [7:0] ChTab   = 8'd9;
   localparam logic [7:0] ChCr    = 8'd13;
   localparam logic [7:0] ChSpace = 8'd32;
   localparam logic [7:0] ChPlus  = 8'd43;
   localparam logic [7:0] ChMinus = 8'd45;
   localparam logic [7:0] ChPoint = 8'd46;
   localparam logic [7:0] ChZero  = 8'd48;
   localparam logic [7:0] ChNine  = 8'd57;
   localparam logic [7:0] ChUpE   = 8'd69;
   localparam logic [7:0] ChLowE  = 8'd101;

   localparam logic [18:0] ExpMax = 19'd32767;

   typedef enum logic [2:0] {
      PH_WS,
      PH_INT,
      PH_FRAC,
      PH_ESIGN,
      PH_EDIG,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic               neg;
      logic [63:0]        acc;
      logic [KeptW-1:0]   kept;
      logic signed [15:0] scale;
      logic               exp_neg;
      logic [14:0]        exp_acc;
      logic               dropped;
      logic               sat;
   } parse_state_type;

   localparam parse_state_type ParseReset = '{
      phase:   PH_WS,
      neg:     1'b0,
      acc:     64'd0,
      kept:    '0,
      scale:   16'sd0,
      exp_neg: 1'b0,
      exp_acc: 15'd0,
      dropped: 1'b0,
      sat:     1'b0
   };

endpackage

// ===== src/dfp_step.sv =====
// ----------------------------------------------------------------------------
// dfp_step: one-character parse step
// Next parse state from the current state and one text character.
// ----------------------------------------------------------------------------
module dfp_step
   import dfp_pkg::*;
(
   input  parse_state_type cur,
   input  logic [7:0]      char_code,
   output parse_state_type nxt
);

   logic        dig;
   logic        blank;
   logic        exp_mark;
   logic [7:0]  diff;
   logic [3:0]  d;
   logic [63:0] acc_x10;
   logic [18:0] exp_x10;
   logic        int_go;
   logic        digit_go;
   logic        frac_go;
   logic        exp_go;
   logic        bump_up;
   logic        bump_dn;

   assign dig      = (char_code >= ChZero) && (char_code <= ChNine);
   assign blank    = (char_code == ChSpace) || ((char_code >= ChTab) && (char_code <= ChCr));
   assign exp_mark = (char_code == ChLowE) || (char_code == ChUpE);
   assign diff     = char_code - ChZero;
   assign d        = diff[3:0];
   assign acc_x10  = (cur.acc << 3) + (cur.acc << 1) + {60'd0, d};
   assign exp_x10  = ({4'd0, cur.exp_acc} << 3) + ({4'd0, cur.exp_acc} << 1) + {15'd0, d};

   always_comb begin
      nxt      = cur;
      int_go   = 1'b0;
      digit_go = 1'b0;
      frac_go  = 1'b0;
      exp_go   = 1'b0;
      bump_up  = 1'b0;
      bump_dn  = 1'b0;

      case (cur.phase)
         PH_WS: begin
            if (blank) begin
               nxt.phase = PH_WS;
            end else if (char_code == ChMinus) begin
               nxt.neg   = 1'b1;
               nxt.phase = PH_INT;
            end else if (char_code == ChPlus) begin
               nxt.phase = PH_INT;
            end else begin
               int_go = 1'b1;
            end
         end
         PH_INT: begin
            int_go = 1'b1;
         end
         PH_FRAC: begin
            if (dig) begin
               digit_go = 1'b1;
               frac_go  = 1'b1;
            end else if (exp_mark) begin
               nxt.phase = PH_ESIGN;
            end else begin
               nxt.phase = PH_DONE;
            end
         end
         PH_ESIGN: begin
            if (char_code == ChMinus) begin
               nxt.exp_neg = 1'b1;
               nxt.phase   = PH_EDIG;
            end else if (char_code == ChPlus) begin
               nxt.phase = PH_EDIG;
            end else if (dig) begin
               exp_go    = 1'b1;
               nxt.phase = PH_EDIG;
            end else begin
               nxt.phase = PH_DONE;
            end
         end
         PH_EDIG: begin
            if (dig) begin
               exp_go = 1'b1;
            end else begin
               nxt.phase = PH_DONE;
            end
         end
         default: begin
            nxt.phase = PH_DONE;
         end
      endcase

      if (int_go) begin
         if (dig) begin
            digit_go  = 1'b1;
            nxt.phase = PH_INT;
         end else if (char_code == ChPoint) begin
            nxt.phase = PH_FRAC;
         end else if (exp_mark) begin
            nxt.phase = PH_ESIGN;
         end else begin
            nxt.phase = PH_DONE;
         end
      end

      if (digit_go) begin
         if ((cur.acc == 64'd0) && (d == 4'd0)) begin
            bump_dn = frac_go;
         end else if (cur.kept < KeptW'(MaxDigits)) begin
            nxt.acc  = acc_x10;
            nxt.kept = cur.kept + 1'b1;
            bump_dn  = frac_go;
         end else begin
            if (d != 4'd0) begin
               nxt.dropped = 1'b1;
            end
            bump_up = !frac_go;
         end
      end

      // scale saturates at the 16-bit limits
      if (bump_up) begin
         if (cur.scale == 16'sh7FFF) begin
            nxt.sat = 1'b1;
         end else begin
            nxt.scale = cur.scale + 16'sd1;
         end
      end
      if (bump_dn) begin
         if (cur.scale == 16'sh8000) begin
            nxt.sat = 1'b1;
         end else begin
            nxt.scale = cur.scale - 16'sd1;
         end
      end

      if (exp_go) begin
         if (exp_x10 > ExpMax) begin
            nxt.exp_acc = 15'h7FFF;
            nxt.sat     = 1'b1;
         end else begin
            nxt.exp_acc = exp_x10[14:0];
         end
      end
   end

endmodule

// ===== src/decimal_float_text_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_float_text_parser: streaming decimal number text parser
// Parses sign, digits, point and exponent into significand and net exponent.
// ----------------------------------------------------------------------------
// Takes one text character per cycle, with tlast on the last character of a
// string. The parse state updates in the cycle a character is accepted (one
// multiply-by-ten and add on the 64-bit digit accumulator); the final state is
// captured in a first register, and the net exponent is formed and saturated
// into a second register, from which the result item is offered. Strings may
// follow each other with no gap; the input stalls only when both result
// registers are full and the output is not ready.
module decimal_float_text_parser
   import dfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata    // [0] negative, [64:1] significand,
                                    // [80:65] dec_exponent, [81] inexact,
                                    // [82] exp_saturated, [87:83] zero
);

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type state_step;
   parse_state_type fin_ff;
   parse_state_type fin_in;
   logic            fin_valid_ff;
   logic            fin_valid_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [87:0]     rsp_data_ff;
   logic [87:0]     rsp_data_in;
   logic            in_acc;
   logic            out_free;
   logic            fin_free;
   logic signed [16:0] exp_s;
   logic signed [16:0] net_sum;
   logic               net_ovf;
   logic [15:0]        net_exp;

   dfp_step u_step (
      .cur       (state_ff),
      .char_code (req_tdata),
      .nxt       (state_step)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fin_free   = !fin_valid_ff || out_free;
   assign req_tready = fin_free;
   assign in_acc     = req_tvalid && fin_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      if (in_acc) begin
         state_in = req_tlast ? ParseReset : state_step;
      end
   end

   always_comb begin
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff;
      if (out_free) begin
         fin_valid_in = 1'b0;
      end
      if (in_acc && req_tlast) begin
         fin_in       = state_step;
         fin_valid_in = 1'b1;
      end
   end

   assign exp_s   = $signed({2'b00, fin_ff.exp_acc});
   assign net_sum = {fin_ff.scale[15], fin_ff.scale} + (fin_ff.exp_neg ? -exp_s : exp_s);
   assign net_ovf = net_sum[16] != net_sum[15];
   assign net_exp = net_ovf ? (net_sum[16] ? 16'h8000 : 16'h7FFF) : net_sum[15:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = fin_valid_ff;
         rsp_data_in  = {5'd0, fin_ff.sat || net_ovf, fin_ff.dropped, net_exp,
                         fin_ff.acc, fin_ff.neg};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ParseReset;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_last_captured: assert property (@(posedge clock) disable iff (reset)
      in_acc && req_tlast |=> fin_valid_ff)
      else $error("last item not captured for result");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      in_acc && req_tlast |=> (state_ff.phase == PH_WS) && (state_ff.acc == 64'd0))
      else $error("parse state not cleared after last item");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.kept <= KeptW'(MaxDigits))
      else $error("kept digit count beyond capacity");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !out_free |=> fin_valid_ff && $stable(fin_ff))
      else $error("pending result lost while output stalled");
`endif

endmodule

// ===== bench/dfp_result_checker.sv =====
// ----------------------------------------------------------------------------
// dfp_result_checker: result checker for the decimal text parser
// Follows every accepted character, parses it alongside the block and keeps
// the numbers it should report in a queue. Each result item that leaves the
// block is compared field by field with the oldest queued number.
// ----------------------------------------------------------------------------
module dfp_result_checker
   import dfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_text
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,   // [0] negative, [64:1] significand,
                                    // [80:65] dec_exponent, [81] inexact,
                                    // [82] exp_saturated, [87:83] zero
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               negative;
      logic [63:0]        significand;
      logic signed [15:0] dec_exponent;
      logic               inexact;
      logic               exp_saturated;
   } number_type;

   number_type expected_numbers[$];

   phase_type   phase;
   logic        neg;
   logic [63:0] sig_acc;
   int          kept;
   int          scale;
   logic        exp_neg;
   int          exp_val;
   logic        dropped;
   logic        sat;
   int          fail_count = 0;

   function automatic bit is_digit(logic [7:0] c);
      return c >= ChZero && c <= ChNine;
   endfunction

   task automatic clear_parse();
      phase   = PH_WS;
      neg     = 1'b0;
      sig_acc = 64'd0;
      kept    = 0;
      scale   = 0;
      exp_neg = 1'b0;
      exp_val = 0;
      dropped = 1'b0;
      sat     = 1'b0;
   endtask

   task automatic bump_scale(int delta);
      int s;
      s = scale + delta;
      if (s > 32767) begin
         s   = 32767;
         sat = 1'b1;
      end
      if (s < -32768) begin
         s   = -32768;
         sat = 1'b1;
      end
      scale = s;
   endtask

   task automatic take_digit(logic [3:0] d, bit in_frac);
      if (sig_acc == 64'd0 && d == 4'd0) begin
         // leading zero: no capacity used
         if (in_frac) bump_scale(-1);
      end else if (kept < MaxDigits) begin
         sig_acc = sig_acc * 64'd10 + 64'(d);
         kept++;
         if (in_frac) bump_scale(-1);
      end else begin
         if (d != 4'd0) dropped = 1'b1;
         if (!in_frac) bump_scale(1);
      end
   endtask

   task automatic take_exp_digit(logic [3:0] d);
      int e;
      e = exp_val * 10 + int'(d);
      if (e > 32767) begin
         e   = 32767;
         sat = 1'b1;
      end
      exp_val = e;
   endtask

   task automatic int_char(logic [7:0] c);
      if (is_digit(c)) begin
         take_digit(4'(c - ChZero), 1'b0);
         phase = PH_INT;
      end else if (c == ChPoint) begin
         phase = PH_FRAC;
      end else if (c == ChUpE || c == ChLowE) begin
         phase = PH_ESIGN;
      end else begin
         phase = PH_DONE;
      end
   endtask

   task automatic absorb_char(logic [7:0] c, logic last);
      number_type num;
      int         net;
      case (phase)
         PH_WS: begin
            if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
            end else if (c == ChMinus) begin
               neg   = 1'b1;
               phase = PH_INT;
            end else if (c == ChPlus) begin
               phase = PH_INT;
            end else begin
               int_char(c);
            end
         end
         PH_INT: int_char(c);
         PH_FRAC: begin
            if (is_digit(c)) take_digit(4'(c - ChZero), 1'b1);
            else if (c == ChUpE || c == ChLowE) phase = PH_ESIGN;
            else phase = PH_DONE;
         end
         PH_ESIGN: begin
            if (c == ChMinus) begin
               exp_neg = 1'b1;
               phase   = PH_EDIG;
            end else if (c == ChPlus) begin
               phase = PH_EDIG;
            end else if (is_digit(c)) begin
               take_exp_digit(4'(c - ChZero));
               phase = PH_EDIG;
            end else begin
               phase = PH_DONE;
            end
         end
         PH_EDIG: begin
            if (is_digit(c)) take_exp_digit(4'(c - ChZero));
            else phase = PH_DONE;
         end
         default: phase = PH_DONE;
      endcase
      if (last) begin
         net = scale + (exp_neg ? -exp_val : exp_val);
         num.exp_saturated = sat;
         if (net > 32767) begin
            net = 32767;
            num.exp_saturated = 1'b1;
         end
         if (net < -32768) begin
            net = -32768;
            num.exp_saturated = 1'b1;
         end
         num.negative     = neg;
         num.significand  = sig_acc;
         num.dec_exponent = 16'(net);
         num.inexact      = dropped;
         expected_numbers.push_back(num);
         clear_parse();
      end
   endtask

   task automatic field_check(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      number_type want;
      if (reset) begin
         clear_parse();
         expected_numbers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_numbers.size() == 0) begin
               $display("%0t: unexpected result item, expected none got %0h", $time,
                        rsp_tdata);
               fail_count++;
            end else begin
               want = expected_numbers.pop_front();
               field_check("negative", 64'(want.negative), 64'(rsp_tdata[0]));
               field_check("significand", want.significand, rsp_tdata[64:1]);
               field_check("dec_exponent", {48'd0, want.dec_exponent},
                           64'(rsp_tdata[80:65]));
               field_check("inexact", 64'(want.inexact), 64'(rsp_tdata[81]));
               field_check("exp_saturated", 64'(want.exp_saturated), 64'(rsp_tdata[82]));
               field_check("padding", 64'd0, 64'(rsp_tdata[87:83]));
            end
         end
         if (req_tvalid && req_tready) absorb_char(req_tdata, req_tlast);
      end
      errors  <= fail_count;
      pending <= expected_numbers.size();
   end

endmodule

// ===== bench/decimal_float_text_parser_tb.sv =====
// ----------------------------------------------------------------------------
// decimal_float_text_parser_tb: testbench for the decimal text parser
// Streams number strings into the parser: a few directed strings, then mostly
// well-formed random numbers mixed with noise. Both sides idle at random; the
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module decimal_float_text_parser_tb
   import dfp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;

   int          errors;
   int          pending;
   bit          calm = 1'b0;
   int          chars_sent = 0;
   logic [7:0]  chars[$];

   decimal_float_text_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dfp_result_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("[decimal_float_text_parser] ERROR");
      $finish;
   end

   task automatic send_char(logic [7:0] c, logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_chars();
      if (chars.size() == 0) chars.push_back(8'($urandom_range(0, 255)));
      foreach (chars[i]) begin
         send_char(chars[i], i == chars.size() - 1);
         chars_sent++;
      end
      chars.delete();
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
   endtask

   task automatic push_digits(int n);
      int lead;
      lead = $urandom_range(0, 1) ? $urandom_range(0, n) : 0;
      for (int i = 0; i < n; i++)
         chars.push_back(i < lead ? ChZero : ChZero + 8'($urandom_range(0, 9)));
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, 4);
      if (r < 8) return $urandom_range(5, 12);
      return $urandom_range(17, 24);
   endfunction

   task automatic make_number();
      int r;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            r = $urandom_range(0, 5);
            chars.push_back(r == 5 ? ChSpace : ChTab + 8'(r));
         end
      end
      case ($urandom_range(0, 2))
         1: chars.push_back(ChMinus);
         2: chars.push_back(ChPlus);
         default: ;
      endcase
      push_digits(pick_len());
      if ($urandom_range(0, 1)) begin
         chars.push_back(ChPoint);
         push_digits(pick_len());
      end
      if ($urandom_range(0, 1)) begin
         chars.push_back($urandom_range(0, 1) ? ChUpE : ChLowE);
         case ($urandom_range(0, 2))
            1: chars.push_back(ChMinus);
            2: chars.push_back(ChPlus);
            default: ;
         endcase
         case ($urandom_range(0, 7))
            0: push_text("32767");
            1: push_text("32768");
            2: push_digits($urandom_range(5, 7));
            default: push_digits($urandom_range(0, 3));
         endcase
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(0, 255)));
   endtask

   // result side: random stall ahead of every item
   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_text("\t-0.5E+3");
      send_chars();
      push_text(" \n+e");
      send_chars();
      push_text("\013\014\0157e-");
      send_chars();
      push_text("9z1");
      send_chars();
      chars.push_back(8'h00);
      send_chars();
      chars.push_back(8'hFF);
      send_chars();

      while (chars_sent < 1350) begin
         if ($urandom_range(0, 9) == 0) calm = !calm;
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
         else
            make_number();
         send_chars();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("[decimal_float_text_parser] OK");
      else
         $display("[decimal_float_text_parser] ERROR");
      $finish;
   end

endmodule
